// ----- hw/rtl/six_step_commutation_sequencer_unit_defines.svh -----
// Assertion helpers for the commutation sequencer.
`ifndef SIX_STEP_COMMUTATION_SEQUENCER_UNIT_DEFINES_SVH
`define SIX_STEP_COMMUTATION_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define SSCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sscs: same-cycle check failed");

// Next-cycle implication, off while reset is held.
`define SSCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sscs: next-cycle check failed");

`endif

// ----- hw/rtl/sscs_pkg.sv -----
`timescale 1ns / 1ps
package sscs_pkg;

  typedef enum logic [1:0] {
    CMD_SET       = 2'd0,
    CMD_ADVANCE   = 2'd1,
    CMD_DISCHARGE = 2'd2
  } sscs_cmd_t;

  localparam logic [3:0] CODE_FREEWHEEL  = 4'd0;
  localparam logic [3:0] CODE_STEP_FIRST = 4'd1;
  localparam logic [3:0] CODE_STEP_LAST  = 4'd6;
  localparam logic [3:0] CODE_BRAKE_LOW  = 4'd7;
  localparam logic [3:0] CODE_BRAKE_HIGH = 4'd8;

  localparam logic [1:0] SENSE_NONE = 2'd0;
  localparam logic [1:0] SENSE_U    = 2'd1;
  localparam logic [1:0] SENSE_V    = 2'd2;
  localparam logic [1:0] SENSE_W    = 2'd3;

  // Phase masks, bit0 U, bit1 V, bit2 W.
  localparam logic [2:0] PH_NONE = 3'b000;
  localparam logic [2:0] PH_U    = 3'b001;
  localparam logic [2:0] PH_V    = 3'b010;
  localparam logic [2:0] PH_W    = 3'b100;
  localparam logic [2:0] PH_ALL  = 3'b111;

  typedef struct packed {
    logic [2:0] high_gates;
    logic [2:0] low_gates;
    logic       error;
    logic [3:0] current_step;
    logic [1:0] sense_phase;
    logic       sense_rising;
    logic       pwm_restart;
  } sscs_result_t;

  function automatic logic is_step(input logic [3:0] code);
    is_step = (code >= CODE_STEP_FIRST) && (code <= CODE_STEP_LAST);
  endfunction

  function automatic logic [2:0] high_of_code(input logic [3:0] code);
    unique case (code)
      4'd1, 4'd2:      high_of_code = PH_U;
      4'd3, 4'd4:      high_of_code = PH_V;
      4'd5, 4'd6:      high_of_code = PH_W;
      CODE_BRAKE_HIGH: high_of_code = PH_ALL;
      default:         high_of_code = PH_NONE;
    endcase
  endfunction

  function automatic logic [2:0] low_of_code(input logic [3:0] code);
    unique case (code)
      4'd1, 4'd6:     low_of_code = PH_V;
      4'd2, 4'd3:     low_of_code = PH_W;
      4'd4, 4'd5:     low_of_code = PH_U;
      CODE_BRAKE_LOW: low_of_code = PH_ALL;
      default:        low_of_code = PH_NONE;
    endcase
  endfunction

  function automatic logic [1:0] sense_of_code(input logic [3:0] code);
    unique case (code)
      4'd1, 4'd4: sense_of_code = SENSE_W;
      4'd2, 4'd5: sense_of_code = SENSE_V;
      4'd3, 4'd6: sense_of_code = SENSE_U;
      default:    sense_of_code = SENSE_NONE;
    endcase
  endfunction

endpackage

// ----- hw/rtl/sscs_channels_if.sv -----
`timescale 1ns / 1ps
interface sscs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [3:0] drive_code;
  logic       keep_step;
  modport source (output valid, command, drive_code, keep_step, input ready);
  modport sink (input valid, command, drive_code, keep_step, output ready);
endinterface

interface sscs_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] high_gates;
  logic [2:0] low_gates;
  logic       error;
  logic [3:0] current_step;
  logic [1:0] sense_phase;
  logic       sense_rising;
  logic       pwm_restart;
  modport source (output valid, high_gates, low_gates, error, current_step, sense_phase,
                  sense_rising, pwm_restart, input ready);
  modport sink (input valid, high_gates, low_gates, error, current_step, sense_phase,
                sense_rising, pwm_restart, output ready);
endinterface

interface sscs_cfg_if;
  logic valid;
  logic ready;
  logic reverse_direction;
  modport source (output valid, reverse_direction, input ready);
  modport sink (input valid, reverse_direction, output ready);
endinterface

// ----- hw/rtl/sscs_step_logic.sv -----
`timescale 1ns / 1ps
// Decode one command against the stored step and gates; produce the result,
// which also carries the next stored step and gate state.
module sscs_step_logic (
  input  logic [1:0]            command,
  input  logic [3:0]            drive_code,
  input  logic                  keep_step,
  input  logic                  reverse,
  input  logic [3:0]            step_cur,
  input  logic [2:0]            high_cur,
  input  logic [2:0]            low_cur,
  output sscs_pkg::sscs_result_t result
);

  logic [3:0] step_adv;
  logic [3:0] step_new;
  logic [2:0] dis_low;

  always_comb begin
    if (!reverse) begin
      step_adv = (step_cur == sscs_pkg::CODE_STEP_LAST) ? sscs_pkg::CODE_STEP_FIRST
                                                        : 4'(step_cur + 4'd1);
    end else begin
      step_adv = (step_cur == sscs_pkg::CODE_STEP_FIRST) ? sscs_pkg::CODE_STEP_LAST
                                                         : 4'(step_cur - 4'd1);
    end
  end

  // Low sides that speed demagnetization ahead of a rising-slope step.
  always_comb begin
    dis_low = sscs_pkg::PH_NONE;
    if (!reverse) begin
      unique case (step_cur)
        4'd1:    dis_low = sscs_pkg::PH_U | sscs_pkg::PH_W;
        4'd3:    dis_low = sscs_pkg::PH_U | sscs_pkg::PH_V;
        4'd5:    dis_low = sscs_pkg::PH_V | sscs_pkg::PH_W;
        default: dis_low = sscs_pkg::PH_NONE;
      endcase
    end else begin
      unique case (step_cur)
        4'd2:    dis_low = sscs_pkg::PH_U | sscs_pkg::PH_V;
        4'd4:    dis_low = sscs_pkg::PH_V | sscs_pkg::PH_W;
        4'd6:    dis_low = sscs_pkg::PH_U | sscs_pkg::PH_W;
        default: dis_low = sscs_pkg::PH_NONE;
      endcase
    end
  end

  always_comb begin
    step_new           = step_cur;
    result.high_gates  = high_cur;
    result.low_gates   = low_cur;
    result.error       = 1'b0;
    result.pwm_restart = 1'b0;
    unique case (command)
      sscs_pkg::CMD_SET: begin
        if (drive_code <= sscs_pkg::CODE_BRAKE_HIGH) begin
          result.high_gates  = sscs_pkg::high_of_code(drive_code);
          result.low_gates   = sscs_pkg::low_of_code(drive_code);
          result.pwm_restart = 1'b1;
          if (!keep_step) begin
            step_new = drive_code;
          end
        end else begin
          result.error = 1'b1;
        end
      end
      sscs_pkg::CMD_ADVANCE: begin
        if (sscs_pkg::is_step(step_cur)) begin
          step_new           = step_adv;
          result.high_gates  = sscs_pkg::high_of_code(step_adv);
          result.low_gates   = sscs_pkg::low_of_code(step_adv);
          result.pwm_restart = 1'b1;
        end else begin
          result.error = 1'b1;
        end
      end
      sscs_pkg::CMD_DISCHARGE: begin
        result.high_gates  = sscs_pkg::PH_NONE;
        result.low_gates   = dis_low;
        result.pwm_restart = 1'b1;
      end
      default: begin
        result.error = 1'b1;
      end
    endcase
    result.current_step = step_new;
    result.sense_phase  = sscs_pkg::sense_of_code(step_new);
    result.sense_rising = sscs_pkg::is_step(step_new) & (~step_new[0] ^ reverse);
  end

endmodule

// ----- hw/rtl/six_step_commutation_sequencer_unit.sv -----
`timescale 1ns / 1ps
// Six-step commutation sequencer for a three-phase bridge.
// in_ch carries one command per transaction: set a drive code (freewheel,
// steps 1 to 6, brake low, brake high, optionally keeping the stored step),
// advance one step, or discharge ahead of a rising-slope step.
// out_ch returns exactly one result per command: gate enables, stored step,
// back-EMF sense phase and slope, error flag and a PWM restart pulse.
// cfg_ch writes the direction bit; write it only while no command is in flight.
// A command taken on in_ch passes through the input register and then the
// result register before it shows on out_ch. Throughput: one command per
// cycle while out_ch is not stalled; the step update is a small table lookup
// and increment decided combinationally.
// Reset clears the stored step to freewheel, all gates off, forward direction
// and both pipeline registers empty.
// When the receiver stalls, the result register holds and the input register
// fills; in_ch.ready drops only once both are occupied.
`include "six_step_commutation_sequencer_unit_defines.svh"
module six_step_commutation_sequencer_unit (
  input  logic              clk,
  input  logic              rst_n,
  sscs_in_if.sink           in_ch,
  sscs_cfg_if.sink          cfg_ch,
  sscs_out_if.source        out_ch
);

  // Input register
  logic       in_valid_r;
  logic [1:0] in_command_r;
  logic [3:0] in_code_r;
  logic       in_keep_r;

  // Architectural state
  logic       reverse_r;
  logic [3:0] step_r;
  logic [2:0] high_r;
  logic [2:0] low_r;

  // Result register
  logic                   out_valid_r;
  sscs_pkg::sscs_result_t out_res_r;

  sscs_pkg::sscs_result_t res_nxt;
  logic                   advance;
  logic                   in_take;
  logic                   out_sense_ok;

  // Move the input register into the result slot when it is free or draining.
  assign advance = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  // Payload: capture on every accepted transaction, no reset needed.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_command_r <= in_ch.command;
      in_code_r    <= in_ch.drive_code;
      in_keep_r    <= in_ch.keep_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reverse_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      reverse_r <= cfg_ch.reverse_direction;
    end
  end

  sscs_step_logic u_step (
    .command    (in_command_r),
    .drive_code (in_code_r),
    .keep_step  (in_keep_r),
    .reverse    (reverse_r),
    .step_cur   (step_r),
    .high_cur   (high_r),
    .low_cur    (low_r),
    .result     (res_nxt)
  );

  // Commit state together with the result so the next command sees it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= sscs_pkg::CODE_FREEWHEEL;
      high_r <= sscs_pkg::PH_NONE;
      low_r  <= sscs_pkg::PH_NONE;
    end else if (advance) begin
      step_r <= res_nxt.current_step;
      high_r <= res_nxt.high_gates;
      low_r  <= res_nxt.low_gates;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.high_gates   = out_res_r.high_gates;
  assign out_ch.low_gates    = out_res_r.low_gates;
  assign out_ch.error        = out_res_r.error;
  assign out_ch.current_step = out_res_r.current_step;
  assign out_ch.sense_phase  = out_res_r.sense_phase;
  assign out_ch.sense_rising = out_res_r.sense_rising;
  assign out_ch.pwm_restart  = out_res_r.pwm_restart;

  assign out_sense_ok = (out_res_r.sense_phase != sscs_pkg::SENSE_NONE) ==
                        sscs_pkg::is_step(out_res_r.current_step);

  // A rejected command never restarts the PWM period.
  `SSCS_ASSERT_NOW(a_err_no_restart, clk, rst_n, out_valid_r && out_res_r.error, !out_res_r.pwm_restart)

  // A sense phase is reported exactly when the stored code is a step.
  `SSCS_ASSERT_NOW(a_sense_on_step, clk, rst_n, out_valid_r, out_sense_ok)

  // Stored step moves only when a command leaves the input register.
  `SSCS_ASSERT_NEXT(a_step_hold, clk, rst_n, !advance, $stable(step_r))

endmodule
